### design/cmac_lea128_mac_assert.svh
// assertion macros shared by the checker
`ifndef CMAC_LEA128_MAC_ASSERT_SVH
`define CMAC_LEA128_MAC_ASSERT_SVH
`define CMAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmac check failed");
`define CMAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmac check failed");
`endif

### design/cmac_pkg.sv
// ----------------------------------------------------------------------------
// cmac_pkg
// shared types, constants and helper functions for the lea-128 cipher and cmac
// ----------------------------------------------------------------------------
package cmac_pkg;
    localparam int unsigned Rounds = 24;
    localparam logic [7:0] Rb = 8'h87;
    localparam logic [7:0] PadMark = 8'h80;
    localparam logic [0:0] CmdAbsorb = 1'b0;
    localparam logic [0:0] CmdFinish = 1'b1;
    localparam logic [0:0] CfgKeyHigh = 1'b0;
    localparam logic [0:0] CfgKeyLow = 1'b1;

    typedef struct packed {
        logic       finish;
        logic [7:0] data;
    } t_item;

    typedef logic [31:0] t_word;

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {x, x} << n;
            rotl = d[63:32];
        end
    endfunction

    function automatic t_word delta(input logic [1:0] i);
        case (i)
            2'd0: delta = 32'hc3efe9db;
            2'd1: delta = 32'h44626b02;
            2'd2: delta = 32'h79e27c8a;
            default: delta = 32'h78df30ec;
        endcase
    endfunction

    function automatic logic [127:0] swap_bytes(input logic [127:0] v);
        logic [127:0] r;
        begin
            for (int i = 0; i < 16; i++) begin
                r[8*i +: 8] = v[8*(15-i) +: 8];
            end
            swap_bytes = r;
        end
    endfunction

    function automatic logic [127:0] dbl(input logic [127:0] v);
        begin
            dbl = {v[126:0], 1'b0} ^ (v[127] ? {120'd0, Rb} : 128'd0);
        end
    endfunction
endpackage

### design/cmac_lea_core.sv
// ----------------------------------------------------------------------------
// cmac_lea_core
// iterative lea-128 encryption, one round per cycle, big-endian block view
// ----------------------------------------------------------------------------
module cmac_lea_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [127:0]   i_key,
    input  logic [127:0]   i_block,
    output logic           o_done,
    output logic [127:0]   o_block
);
    logic [4:0]   r_round;
    logic         r_busy;
    logic         r_done;
    cmac_pkg::t_word r_t [4];
    cmac_pkg::t_word r_x [4];
    cmac_pkg::t_word n_t [4];
    logic [127:0] w_kle;
    logic [127:0] w_ble;
    logic [127:0] w_out;

    assign w_kle = cmac_pkg::swap_bytes(i_key);
    assign w_ble = cmac_pkg::swap_bytes(i_block);

    always_comb begin
        cmac_pkg::t_word d;
        d = cmac_pkg::delta(r_round[1:0]);
        n_t[0] = cmac_pkg::rotl(r_t[0] + cmac_pkg::rotl(d, r_round), 5'd1);
        n_t[1] = cmac_pkg::rotl(r_t[1] + cmac_pkg::rotl(d, r_round + 5'd1), 5'd3);
        n_t[2] = cmac_pkg::rotl(r_t[2] + cmac_pkg::rotl(d, r_round + 5'd2), 5'd6);
        n_t[3] = cmac_pkg::rotl(r_t[3] + cmac_pkg::rotl(d, r_round + 5'd3), 5'd11);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                for (int j = 0; j < 4; j++) begin
                    r_t[j] <= w_kle[32*j +: 32];
                    r_x[j] <= w_ble[32*j +: 32];
                end
            end else if (r_busy) begin
                for (int j = 0; j < 4; j++) r_t[j] <= n_t[j];
                r_x[0] <= cmac_pkg::rotl((r_x[0] ^ n_t[0]) + (r_x[1] ^ n_t[1]), 5'd9);
                r_x[1] <= cmac_pkg::rotl((r_x[1] ^ n_t[2]) + (r_x[2] ^ n_t[1]), 5'd27);
                r_x[2] <= cmac_pkg::rotl((r_x[2] ^ n_t[3]) + (r_x[3] ^ n_t[1]), 5'd29);
                r_x[3] <= r_x[0];
                r_round <= r_round + 5'd1;
                if (r_round == 5'(cmac_pkg::Rounds - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign w_out = {r_x[3], r_x[2], r_x[1], r_x[0]};
    assign o_block = cmac_pkg::swap_bytes(w_out);
    assign o_done = r_done;
endmodule

### design/cmac_front.sv
// ----------------------------------------------------------------------------
// cmac_front
// two-entry item queue between the stream input and the cmac engine
// ----------------------------------------------------------------------------
module cmac_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cmac_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_take,
    output cmac_pkg::t_item o_item
);
    cmac_pkg::t_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= i_item;
                r_wp <= ~r_wp;
            end
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

### design/cmac_back.sv
// ----------------------------------------------------------------------------
// cmac_back
// cmac sequencer: subkey derivation, chaining, padding and tag output
// ----------------------------------------------------------------------------
module cmac_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_take,
    input  cmac_pkg::t_item i_item,
    input  logic [127:0]    i_key,
    input  logic            i_key_wr,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [127:0]    o_tag
);
    typedef enum logic [2:0] {
        S_IDLE, S_SUB, S_CHAIN, S_FIN, S_OUT
    } t_state;

    t_state       r_state;
    logic [127:0] r_chain, r_pend, r_k1, r_k2, r_tag;
    logic [4:0]   r_cnt;
    logic         r_ready, r_tvalid;
    logic         r_start;
    logic [127:0] r_cin;
    logic         w_done;
    logic [127:0] w_cout, w_last;

    cmac_lea_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_key(i_key),
        .i_block(r_cin), .o_done(w_done), .o_block(w_cout)
    );

    always_comb begin
        w_last = r_pend;
        if (r_cnt[4]) begin
            w_last = r_pend ^ r_k1;
        end else begin
            w_last[8*(15-r_cnt[3:0]) +: 8] = cmac_pkg::PadMark;
            w_last = w_last ^ r_k2;
        end
    end

    // an item is taken only in idle with subkeys ready and no key write; a finish also needs the output free
    assign o_take = (r_state == S_IDLE) && r_ready && i_valid && !i_key_wr &&
                    !(i_item.finish && r_tvalid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chain <= '0;
            r_pend  <= '0;
            r_cnt   <= '0;
            r_ready <= 1'b0;
            r_tvalid <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_tvalid && i_tready) r_tvalid <= 1'b0;
            if (i_key_wr) r_ready <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!r_ready && !i_key_wr && i_valid) begin
                        r_cin <= '0;
                        r_start <= 1'b1;
                        r_state <= S_SUB;
                    end else if (o_take) begin
                        if (i_item.finish) begin
                            r_cin <= r_chain ^ w_last;
                            r_start <= 1'b1;
                            r_state <= S_FIN;
                        end else if (r_cnt[4]) begin
                            r_cin <= r_chain ^ r_pend;
                            r_start <= 1'b1;
                            r_pend <= {i_item.data, 120'd0};
                            r_cnt <= 5'd1;
                            r_state <= S_CHAIN;
                        end else begin
                            r_pend[8*(15-r_cnt[3:0]) +: 8] <= i_item.data;
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                S_SUB: if (w_done) begin
                    r_k1 <= cmac_pkg::dbl(w_cout);
                    r_k2 <= cmac_pkg::dbl(cmac_pkg::dbl(w_cout));
                    r_ready <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_CHAIN: if (w_done) begin
                    r_chain <= w_cout;
                    r_state <= S_IDLE;
                end
                S_FIN: if (w_done) begin
                    r_tag <= w_cout;
                    r_tvalid <= 1'b1;
                    r_chain <= '0;
                    r_pend <= '0;
                    r_cnt <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tag = r_tag;
endmodule

### design/cmac_lea128_mac.sv
// ----------------------------------------------------------------------------
// cmac_lea128_mac
// cmac tag over a byte stream with the lea-128 cipher
// ----------------------------------------------------------------------------
// each encryption occupies the engine for a start step, 24 rounds and a collect
// step: the first byte of every block after the first starts a chaining
// encryption and the next item waits behind it; a finish holds the engine until
// the tag is registered; the first item after reset or a key write waits for
// subkey derivation. the tag waits in an output register while further bytes
// are absorbed, and a finish waits until the previous tag has been taken.
module cmac_lea128_mac (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // msg_byte
    input  logic          s_axis_tuser,   // command
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // tag_high, tag_low (tag_high in low bits)
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data
);
    logic [63:0] r_key_high, r_key_low;
    logic q_valid, q_take;
    cmac_pkg::t_item q_item, w_in;
    logic [127:0] w_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cmac_pkg::CfgKeyHigh: r_key_high <= i_cfg_data;
                cmac_pkg::CfgKeyLow:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_in.finish = (s_axis_tuser == cmac_pkg::CmdFinish);
    assign w_in.data = s_axis_tdata;

    cmac_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_item(w_in), .o_valid(q_valid),
        .i_take(q_take), .o_item(q_item)
    );

    cmac_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_take(q_take),
        .i_item(q_item), .i_key({r_key_high, r_key_low}), .i_key_wr(i_cfg_we),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready), .o_tag(w_tag)
    );

    assign m_axis_tdata = {w_tag[63:0], w_tag[127:64]};
endmodule

### design/cmac_check.sv
// ----------------------------------------------------------------------------
// cmac_check
// port-level checks of the cmac stream block
// ----------------------------------------------------------------------------
`include "cmac_lea128_mac_assert.svh"
module cmac_check (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    `CMAC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `CMAC_ASSERT_IMPL(a_known, i_clk, i_rst_n, 1'b1,
        !$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready}))
    `CMAC_ASSERT_NEXT(a_drain, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready,
        !m_axis_tvalid)
endmodule

bind cmac_lea128_mac cmac_check u_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

### verif/cmac_lea128_mac_tb.sv
// ----------------------------------------------------------------------------
// cmac_lea128_mac_tb
// checks the cmac tag stream against an in-bench lea-128 cmac predictor,
// with random gaps on both stream sides, key changes between phases and a
// long receiver hold-off that backs the block up
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cmac_lea128_mac_tb;
    localparam int WatchLimit = 6000;
    localparam int SettleCycles = 100;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_tag;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         i_cfg_we;
    logic [0:0]   i_cfg_index;
    logic [63:0]  i_cfg_data;

    cmac_lea128_mac uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    cmac_pkg::t_item pending_items[$];
    t_tag         tags_due[$];
    int           fail_cnt = 0;
    int           item_cnt = 0;
    bit           no_idle = 0;
    bit           hold_req = 0;
    bit           hold_done = 0;
    int           hold_cnt = 0;
    int           tx_gap = 0;
    int           rx_gap = 0;
    int           idle_cycles = 0;
    bit           in_taken = 0;

    // predictor state, bytes packed with byte 0 in the low bits
    logic [63:0]  key_hi_m, key_lo_m;
    logic [127:0] chain_m, block_m, k1_m, k2_m;
    int           fill_m;
    bit           subkeys_ok;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rol32(logic [31:0] x, int n);
        n = n & 31;
        if (n == 0) return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [127:0] lea_cipher(logic [127:0] blk);
        logic [31:0] dl[4];
        logic [31:0] t[4], x[4];
        logic [31:0] n0, n1, n2;
        logic [127:0] kb, r;
        dl = '{32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec};
        for (int i = 0; i < 8; i++) begin
            kb[8*i +: 8] = key_hi_m[56-8*i +: 8];
            kb[64+8*i +: 8] = key_lo_m[56-8*i +: 8];
        end
        for (int j = 0; j < 4; j++) begin
            t[j] = kb[32*j +: 32];
            x[j] = blk[32*j +: 32];
        end
        for (int i = 0; i < cmac_pkg::Rounds; i++) begin
            t[0] = rol32(t[0] + rol32(dl[i%4], i), 1);
            t[1] = rol32(t[1] + rol32(dl[i%4], i + 1), 3);
            t[2] = rol32(t[2] + rol32(dl[i%4], i + 2), 6);
            t[3] = rol32(t[3] + rol32(dl[i%4], i + 3), 11);
            n0 = rol32((x[0] ^ t[0]) + (x[1] ^ t[1]), 9);
            n1 = rol32((x[1] ^ t[2]) + (x[2] ^ t[1]), 27);
            n2 = rol32((x[2] ^ t[3]) + (x[3] ^ t[1]), 29);
            x[3] = x[0];
            x[0] = n0;
            x[1] = n1;
            x[2] = n2;
        end
        for (int j = 0; j < 4; j++) r[32*j +: 32] = x[j];
        return r;
    endfunction

    // gf(2^128) doubling, byte 0 most significant
    function automatic logic [127:0] gf_double(logic [127:0] s);
        logic [127:0] d;
        logic [7:0] nxt;
        for (int i = 0; i < 16; i++) begin
            nxt = (i < 15) ? {7'd0, s[8*(i+1)+7]} : 8'd0;
            d[8*i +: 8] = {s[8*i +: 7], 1'b0} | nxt;
        end
        if (s[7]) d[127:120] = d[127:120] ^ cmac_pkg::Rb;
        return d;
    endfunction

    task automatic predict_tag(cmac_pkg::t_item it);
        logic [127:0] sub;
        t_tag tg;
        if (!subkeys_ok) begin
            k1_m = gf_double(lea_cipher(128'd0));
            k2_m = gf_double(k1_m);
            subkeys_ok = 1;
        end
        if (it.finish == cmac_pkg::CmdAbsorb) begin
            if (fill_m >= 16) begin
                chain_m = lea_cipher(chain_m ^ block_m);
                fill_m = 0;
            end
            block_m[8*fill_m +: 8] = it.data;
            fill_m++;
        end else begin
            if (fill_m >= 16) begin
                sub = k1_m;
            end else begin
                block_m[8*fill_m +: 8] = cmac_pkg::PadMark;
                for (int i = fill_m + 1; i < 16; i++) block_m[8*i +: 8] = 8'd0;
                sub = k2_m;
            end
            chain_m = lea_cipher(chain_m ^ block_m ^ sub);
            for (int i = 0; i < 8; i++) begin
                tg.hi[56-8*i +: 8] = chain_m[8*i +: 8];
                tg.lo[56-8*i +: 8] = chain_m[64+8*i +: 8];
            end
            tags_due.push_back(tg);
            chain_m = '0;
            block_m = '0;
            fill_m = 0;
        end
    endtask

    task automatic report(string what, logic [63:0] want, logic [63:0] got);
        $display("mismatch %s: expected %h got %h", what, want, got);
        fail_cnt++;
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                cmac_pkg::t_item it;
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= it.finish;
                s_axis_tdata <= it.data;
                tx_gap <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_gap <= pick_gap();
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        cmac_pkg::t_item it;
        t_tag tg;
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            it.finish = s_axis_tuser;
            it.data = s_axis_tdata;
            predict_tag(it);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tags_due.size() == 0) begin
                report("unexpected tag", 64'd0, m_axis_tdata[63:0]);
            end else begin
                tg = tags_due.pop_front();
                if (m_axis_tdata[63:0] !== tg.hi) report("tag_high", tg.hi, m_axis_tdata[63:0]);
                if (m_axis_tdata[127:64] !== tg.lo)
                    report("tag_low", tg.lo, m_axis_tdata[127:64]);
            end
            idle_cycles <= 0;
        end else if (in_taken) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic push_item(logic fin, logic [7:0] b);
        cmac_pkg::t_item it;
        it.finish = fin;
        it.data = b;
        pending_items.push_back(it);
        item_cnt++;
    endtask

    task automatic push_msg(int len);
        for (int i = 0; i < len; i++) push_item(cmac_pkg::CmdAbsorb, 8'($urandom));
        push_item(cmac_pkg::CmdFinish, 8'($urandom));
    endtask

    task automatic write_key(logic [0:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == cmac_pkg::CfgKeyHigh) key_hi_m = val;
        else key_lo_m = val;
        subkeys_ok = 0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !s_axis_tvalid && tags_due.size() == 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic random_run(int n);
        int r;
        int stop;
        stop = item_cnt + n;
        while (item_cnt < stop) begin
            r = $urandom_range(0, 19);
            if (r == 0) push_item(cmac_pkg::CmdFinish, 8'($urandom));
            else if (r == 1) begin
                for (int i = $urandom_range(1, 20); i > 0; i--)
                    push_item(cmac_pkg::CmdAbsorb, 8'($urandom));
            end else if (r < 4) push_msg($urandom_range(30, 70));
            else push_msg($urandom_range(0, 33));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = cmac_pkg::CfgKeyHigh;
        i_cfg_data = 64'd0;
        key_hi_m = '0;
        key_lo_m = '0;
        chain_m = '0;
        block_m = '0;
        k1_m = '0;
        k2_m = '0;
        fill_m = 0;
        subkeys_ok = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset key, empty message, boundary lengths, byte extremes
        push_item(cmac_pkg::CmdFinish, 8'hff);
        for (int i = 0; i < 16; i++) push_item(cmac_pkg::CmdAbsorb, 8'hff);
        push_item(cmac_pkg::CmdFinish, 8'h00);
        push_item(cmac_pkg::CmdAbsorb, 8'h00);
        push_item(cmac_pkg::CmdFinish, 8'h5a);
        drain();
        write_key(cmac_pkg::CfgKeyHigh, 64'hffff_ffff_ffff_ffff);
        write_key(cmac_pkg::CfgKeyLow, 64'hffff_ffff_ffff_ffff);
        push_msg(15);
        push_msg(17);
        drain();

        // pressure: short messages while the receiver holds off
        write_key(cmac_pkg::CfgKeyHigh, {$urandom, $urandom});
        write_key(cmac_pkg::CfgKeyLow, {$urandom, $urandom});
        hold_req = 1;
        for (int i = 0; i < 30; i++) push_msg($urandom_range(0, 3));
        random_run(200);
        drain();

        // key change in the middle of a message
        for (int i = 0; i < 20; i++) push_item(cmac_pkg::CmdAbsorb, 8'($urandom));
        drain();
        write_key(cmac_pkg::CfgKeyLow, {$urandom, $urandom});
        random_run(220);
        drain();

        no_idle = 1;
        write_key(cmac_pkg::CfgKeyHigh, 64'd0);
        write_key(cmac_pkg::CfgKeyLow, 64'd0);
        random_run(200);
        drain();
        no_idle = 0;

        write_key(cmac_pkg::CfgKeyHigh, {$urandom, $urandom});
        write_key(cmac_pkg::CfgKeyLow, {$urandom, $urandom});
        random_run(150);
        drain();

        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/cmac_pkg.sv
design/cmac_lea_core.sv
design/cmac_front.sv
design/cmac_back.sv
design/cmac_lea128_mac.sv
design/cmac_check.sv
verif/cmac_lea128_mac_tb.sv
